// ----- src/lrcp_pkg.sv -----
// Shared types and constants for the letter repeat code packer.
// Used by the encoder, the result queue and the top level; no dependencies.
package lrcp_pkg;

   // Character codes seen on the input beat
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_NL   = 8'h0a;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_J    = 8'h6a;
   localparam logic [7:0] NO_LETTER = 8'hff;

   // Code emitted for a repeated letter
   localparam logic [1:0] REPEAT_CODE = 2'b11;

   // Bits in one packed byte
   localparam int unsigned BYTE_BITS = 8;

   // Default depth of the result queue (must be at least 2)
   localparam int unsigned RSP_DEPTH_DEFAULT = 4;

   // One result beat
   typedef struct packed {
      logic [BYTE_BITS-1:0] code_byte;
      logic                 aborted;
      logic                 final_of_message;
      logic                 last_of_run;
   } result_type;

   // Results produced by one input beat, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ----- src/lrcp_encoder.sv -----
// Packing state and per-beat encode logic of the letter repeat code packer.
// Depends on lrcp_pkg; emits up to two results per fired beat.
module lrcp_encoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             char_in,
   input  logic                   message_end,
   output lrcp_pkg::push_type     push
);
   import lrcp_pkg::*;

   logic [7:0] previous_letter_ff, previous_letter_in;
   logic [7:0] pending_bits_ff, pending_bits_in;
   logic [2:0] fill_count_ff, fill_count_in;
   logic       abort_flag_ff, abort_flag_in;

   logic       skip_char;
   logic       bad_char;
   logic       repeat_letter;
   logic [3:0] code;
   logic [7:0] acc;
   logic [3:0] fill_sum;
   logic       have_full;
   logic [7:0] full_byte;
   logic [7:0] carry_byte;
   logic       flush;
   result_type full_res;
   result_type flush_res;
   result_type abort_res;

   // Classify the character and build its code
   always_comb begin
      skip_char     = (char_in == CHAR_NUL) || (char_in == CHAR_NL);
      bad_char      = !skip_char && ((char_in < CHAR_A) || (char_in > CHAR_J));
      repeat_letter = (char_in == previous_letter_ff);
      code          = 4'(char_in - CHAR_A + 8'd1);
   end

   // Merge the code into the partial byte and split off a full byte
   always_comb begin
      acc = pending_bits_ff;
      if (repeat_letter) begin
         acc      = acc | ({6'd0, REPEAT_CODE} << (3'd6 - fill_count_ff));
         fill_sum = {1'b0, fill_count_ff} + 4'd2;
      end else begin
         if (fill_count_ff <= 3'd4) begin
            acc = acc | ({4'd0, code} << (3'd4 - fill_count_ff));
         end else begin
            acc = acc | ({4'd0, code} >> (fill_count_ff - 3'd4));
         end
         fill_sum = {1'b0, fill_count_ff} + 4'd4;
      end
      have_full  = fill_sum[3];
      full_byte  = acc;
      // low 2 bits of a straddling code open the next byte
      carry_byte = (fill_sum[2:0] == 3'd2) ? {code[1:0], 6'd0} : 8'd0;
   end

   // Next state and results
   always_comb begin
      previous_letter_in = previous_letter_ff;
      pending_bits_in    = pending_bits_ff;
      fill_count_in      = fill_count_ff;
      abort_flag_in      = abort_flag_ff;
      push               = '0;
      flush              = 1'b0;
      abort_res          = '{code_byte: 8'd0, aborted: 1'b1,
                             final_of_message: 1'b1, last_of_run: 1'b1};
      full_res           = '{code_byte: full_byte, aborted: 1'b0,
                             final_of_message: 1'b0, last_of_run: 1'b1};
      flush_res          = '{code_byte: pending_bits_ff, aborted: 1'b0,
                             final_of_message: 1'b1, last_of_run: 1'b1};

      if (fire) begin
         if (abort_flag_ff) begin
            // ignore beats until the message ends
         end else if (bad_char) begin
            push.count = 2'd1;
            push.first = abort_res;
            abort_flag_in = 1'b1;
         end else if (skip_char) begin
            flush = (fill_count_ff != 3'd0);
            if (message_end && flush) begin
               push.count = 2'd1;
               push.first = flush_res;
            end
         end else begin
            if (!repeat_letter) begin
               previous_letter_in = char_in;
            end
            pending_bits_in = have_full ? carry_byte : acc;
            fill_count_in   = fill_sum[2:0];
            flush           = (fill_sum[2:0] != 3'd0);
            flush_res.code_byte = pending_bits_in;
            if (message_end) begin
               if (have_full && flush) begin
                  push.count = 2'd2;
                  full_res.last_of_run = 1'b0;
                  push.first  = full_res;
                  push.second = flush_res;
               end else if (have_full) begin
                  push.count = 2'd1;
                  full_res.final_of_message = 1'b1;
                  push.first = full_res;
               end else if (flush) begin
                  push.count = 2'd1;
                  push.first = flush_res;
               end
            end else if (have_full) begin
               push.count = 2'd1;
               push.first = full_res;
            end
         end

         // return to the idle state at every message end
         if (message_end) begin
            previous_letter_in = NO_LETTER;
            pending_bits_in    = 8'd0;
            fill_count_in      = 3'd0;
            abort_flag_in      = 1'b0;
         end
      end
   end

   // Hold the packing state
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_letter_ff <= NO_LETTER;
         pending_bits_ff    <= 8'd0;
         fill_count_ff      <= 3'd0;
         abort_flag_ff      <= 1'b0;
      end else begin
         previous_letter_ff <= previous_letter_in;
         pending_bits_ff    <= pending_bits_in;
         fill_count_ff      <= fill_count_in;
         abort_flag_ff      <= abort_flag_in;
      end
   end

endmodule

// ----- src/lrcp_rsp_queue.sv -----
// Result queue of the letter repeat code packer: takes up to two results a
// cycle from the encoder and hands them out one beat at a time. Uses lrcp_pkg.
module lrcp_rsp_queue #(
   parameter int unsigned DEPTH = lrcp_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrcp_pkg::push_type     push,
   output logic                   room_for_two,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output lrcp_pkg::result_type   rsp_result
);
   import lrcp_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   result_type           entries [DEPTH];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [PtrWidth-1:0]  wr_ptr_next;
   logic [PtrWidth-1:0]  wr_ptr_next2;
   logic                 pop;

   // Wrap a pointer at the queue depth
   function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] ptr);
      return (ptr == PtrWidth'(DEPTH - 1)) ? '0 : ptr + PtrWidth'(1);
   endfunction

   // Pointer and count bookkeeping
   always_comb begin
      pop          = rsp_tvalid && rsp_tready;
      wr_ptr_next  = bump(wr_ptr_ff);
      wr_ptr_next2 = bump(wr_ptr_next);
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = wr_ptr_next2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntWidth'(push.count) - CntWidth'(pop);
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed results in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries[wr_ptr_next] <= push.second;
      end
   end

   assign room_for_two = (count_ff <= CntWidth'(DEPTH - 2));
   assign rsp_tvalid   = (count_ff != '0);
   assign rsp_result   = entries[rd_ptr_ff];

endmodule

// ----- src/letter_repeat_code_packer_core.sv -----
// Top level of the letter repeat code packer: input register, encoder and
// result queue. Depends on lrcp_pkg, lrcp_encoder and lrcp_rsp_queue.
//
// Takes one character per beat and packs a..j into 4-bit codes (a=1..j=10),
// or the 2-bit code 11 when a letter repeats the one before; NUL and newline
// are skipped. Codes fill bytes MSB first and each full byte is sent out;
// the beat with tlast flushes a partial byte padded with zeros. Any other
// character ends the message with one result flagged aborted, and later beats
// are dropped until tlast. One input beat is taken per cycle while the queue has
// room: the beat is registered, encoded once the queue can take its results,
// and its results land in a queue that drains one result per cycle while the
// result side is ready, so a result passes the input register and the queue
// before it shows on the output. A beat that ends a message can give two results; the input
// stalls only while the queue has fewer than two free slots, which depends
// on how fast the result side takes beats.
module letter_repeat_code_packer_core #(
   parameter int unsigned RSP_DEPTH = lrcp_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // Input beats
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // message_end
   // Result beats
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] code_byte
   output logic [1:0] rsp_tuser,   // [0] aborted, [1] last_of_run
   output logic       rsp_tlast    // final_of_message
);
   import lrcp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_end_ff, in_end_in;
   logic       room_for_two;
   logic       fire;
   push_type   push;
   result_type rsp_result;

   // Encode the registered beat when the queue can take its results
   assign fire       = in_valid_ff && room_for_two;
   assign req_tready = !in_valid_ff || room_for_two;

   // Input register: load on accept, drop once encoded
   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_end_in   = in_end_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
         in_end_in   = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_end_ff  <= in_end_in;
   end

   lrcp_encoder u_encoder (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .char_in     (in_char_ff),
      .message_end (in_end_ff),
      .push        (push)
   );

   lrcp_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_result   (rsp_result)
   );

   assign rsp_tdata = rsp_result.code_byte;
   assign rsp_tuser = {rsp_result.last_of_run, rsp_result.aborted};
   assign rsp_tlast = rsp_result.final_of_message;

   // An abort beat carries a zero byte and closes the message
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == 8'd0) && rsp_tlast && rsp_tuser[1])
      else $error("abort result malformed");

   // The final beat of a message is always the last of its input beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("final beat not last of run");

   // A held input beat stays put until the queue has room
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room_for_two |=> in_valid_ff && $stable(in_char_ff)
         && $stable(in_end_ff))
      else $error("input register lost a beat");

   // Nothing is pushed unless a beat was encoded
   assert property (@(posedge clock) disable iff (reset)
      !fire |-> (push.count == 2'd0))
      else $error("push without encoded beat");

endmodule

// ----- tb/sv/letter_repeat_code_packer_core_tb.sv -----
// Self-checking testbench for letter_repeat_code_packer_core: directed and random messages,
// predicted beat by beat against an in-bench packer model with random idling and stalls.
// Depends on lrcp_pkg and the letter_repeat_code_packer_core RTL.
`timescale 1ns / 1ps

module letter_repeat_code_packer_core_tb;
   import lrcp_pkg::*;

   localparam int unsigned RSP_HOLD_CYCLES = 200;
   localparam int unsigned DRAIN_CYCLES    = 20;
   localparam int unsigned RANDOM_ITEMS    = 1050;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   // Packer state as predicted from the accepted input beats
   logic [7:0] last_letter;
   logic [7:0] pending_byte;
   int unsigned filled_bits;
   logic       in_abort;

   result_type expected_bytes[$];
   int unsigned error_count = 0;
   int unsigned char_count = 0;
   int unsigned req_idle_pct = 13;
   int unsigned rsp_idle_pct = 13;
   logic        rsp_hold = 1'b0;
   event        rsp_hold_start;

   letter_repeat_code_packer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Drive the result side ready, with random idling and an occasional long hold-off
   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Count out a long receiver hold-off on request
   initial begin
      forever begin
         @(rsp_hold_start);
         rsp_hold <= 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // Compare each result beat with the oldest predicted one
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result beat: code_byte %h tuser %b tlast %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.code_byte) begin
               $error("code_byte: expected %h, got %h", want.code_byte, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.aborted) begin
               $error("aborted: expected %b, got %b", want.aborted, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tlast !== want.final_of_message) begin
               $error("final_of_message: expected %b, got %b", want.final_of_message,
                      rsp_tlast);
               error_count++;
            end
            if (rsp_tuser[1] !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b", want.last_of_run, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   // Return the predicted packer to its idle state
   task automatic clear_packer();
      last_letter  = NO_LETTER;
      pending_byte = 8'h00;
      filled_bits  = 0;
      in_abort     = 1'b0;
   endtask

   // Advance the packer by one accepted character and queue the bytes it produces
   task automatic predict_codes(input logic [7:0] ch, input logic msg_end);
      int unsigned acc;
      int unsigned fill;
      int unsigned code;
      logic        have_full;
      logic [7:0]  full_byte;
      logic        flush;
      have_full = 1'b0;
      full_byte = 8'h00;
      // Drop everything after an abort until the message ends
      if (in_abort) begin
         if (msg_end) clear_packer();
         return;
      end
      if (ch != CHAR_NUL && ch != CHAR_NL) begin
         if (ch < CHAR_A || ch > CHAR_J) begin
            expected_bytes.push_back(result_type'{8'h00, 1'b1, 1'b1, 1'b1});
            if (msg_end) clear_packer();
            else in_abort = 1'b1;
            return;
         end
         acc  = 32'(pending_byte);
         fill = filled_bits;
         code = ch - CHAR_A + 1;
         if (ch == last_letter) begin
            acc  |= REPEAT_CODE << (6 - fill);
            fill += 2;
         end else begin
            last_letter = ch;
            // A 4-bit code entered at 6 filled bits splits across two bytes
            if (fill <= 4) acc |= code << (4 - fill);
            else acc |= code >> (fill - 4);
            fill += 4;
         end
         acc &= 8'hff;
         if (fill >= BYTE_BITS) begin
            have_full = 1'b1;
            full_byte = acc[7:0];
            fill     -= BYTE_BITS;
            acc       = (fill == 2) ? ((code << 6) & 8'hff) : 0;
         end
         pending_byte = acc[7:0];
         filled_bits  = fill;
      end
      if (msg_end) begin
         flush = (filled_bits != 0);
         if (have_full) expected_bytes.push_back(result_type'{full_byte, 1'b0, !flush, !flush});
         if (flush) expected_bytes.push_back(result_type'{pending_byte, 1'b0, 1'b1, 1'b1});
         clear_packer();
      end else if (have_full) begin
         expected_bytes.push_back(result_type'{full_byte, 1'b0, 1'b0, 1'b1});
      end
   endtask

   // Offer one character beat, hold it until accepted, then predict its results
   task automatic send_char(input logic [7:0] ch, input logic msg_end);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= msg_end;
      do @(posedge clock); while (!req_tready);
      predict_codes(ch, msg_end);
      char_count++;
   endtask

   // Stop offering beats and wait until every predicted result has arrived
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // Send one message of mostly valid letters, biased toward repeats
   task automatic send_random_message();
      int unsigned len;
      int unsigned pick;
      logic [7:0]  prev;
      logic [7:0]  ch;
      len  = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      prev = CHAR_A + 8'($urandom_range(9));
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 42) ch = prev;
         else if (pick < 93) ch = CHAR_A + 8'($urandom_range(9));
         else if (pick < 96) ch = $urandom_range(1) ? CHAR_NUL : CHAR_NL;
         else ch = 8'($urandom_range(255));
         if (ch >= CHAR_A && ch <= CHAR_J) prev = ch;
         send_char(ch, i == len - 1);
      end
   endtask

   // Boundary characters, split codes, double results and aborts
   task automatic test_directed();
      // Split code followed by a two-result end
      send_char("a", 1'b0);
      send_char("a", 1'b0);
      send_char("b", 1'b1);
      // Full byte on the final beat, nothing left to flush
      send_char("a", 1'b0);
      send_char("b", 1'b1);
      // Highest letter with a run of repeats
      send_char("j", 1'b0);
      send_char("j", 1'b0);
      send_char("j", 1'b0);
      send_char("j", 1'b0);
      send_char("j", 1'b1);
      // Only skipped characters: no result at all
      send_char(CHAR_NUL, 1'b0);
      send_char(CHAR_NL, 1'b1);
      // Abort mid-message, then ignored beats up to the end
      send_char("c", 1'b0);
      send_char(8'h60, 1'b0);
      send_char("d", 1'b0);
      send_char(CHAR_NUL, 1'b1);
      // Abort on the final beat, then an abort on a message's first beat
      send_char("e", 1'b0);
      send_char(8'h6b, 1'b1);
      send_char(8'hff, 1'b0);
      send_char(CHAR_NL, 1'b1);
      // Skipped characters between letters
      send_char("f", 1'b0);
      send_char(CHAR_NL, 1'b0);
      send_char("g", 1'b0);
      send_char("h", 1'b1);
      // Same letter at the start of the next message is not a repeat
      send_char("h", 1'b1);
   endtask

   // Random messages with idling on both sides
   task automatic test_random_messages(input int unsigned target);
      while (char_count < target) send_random_message();
   endtask

   // Random messages with neither side idling
   task automatic test_full_rate(input int unsigned target);
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      while (char_count < target) send_random_message();
      req_idle_pct = 13;
      rsp_idle_pct <= 13;
   endtask

   // Hold off the receiver while a stream of new letters fills the block
   task automatic test_output_stall();
      req_idle_pct = 0;
      -> rsp_hold_start;
      for (int unsigned i = 0; i < 40; i++) begin
         send_char(CHAR_A + 8'(i % 10), i == 39);
      end
      req_idle_pct = 13;
   endtask

   // Pause the sender until everything has drained, between two bursts
   task automatic test_drain_pause();
      repeat (4) send_random_message();
      wait_for_results();
      repeat (4) send_random_message();
   endtask

   initial begin
      clear_packer();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_messages(RANDOM_ITEMS * 6 / 10);
      test_full_rate(char_count + 250);
      test_output_stall();
      test_drain_pause();
      test_random_messages(RANDOM_ITEMS + 25);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected result beats never arrived", expected_bytes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("letter_repeat_code_packer_core_tb: clean");
      end else begin
         $display("letter_repeat_code_packer_core_tb: errors");
      end
      $finish;
   end

   // Bound the run in case the block hangs
   initial begin
      #2000000;
      $display("letter_repeat_code_packer_core_tb: errors");
      $finish;
   end

endmodule
